// ----- rtl/memory_map_bank_decoder_assert.svh -----
// Assertion macros shared by the memory map decoder RTL.
`ifndef MEMORY_MAP_BANK_DECODER_ASSERT_SVH
`define MEMORY_MAP_BANK_DECODER_ASSERT_SVH

// A condition that holds at every clock edge out of reset.
`define MMBD_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("mmbd invariant violated");

// A condition in this cycle implies another in the same cycle.
`define MMBD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mmbd implication violated");

// A condition in this cycle implies another in the next cycle.
`define MMBD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mmbd next-cycle check violated");

`endif

// ----- rtl/mmbd_pkg.sv -----
`timescale 1ns / 1ps

package mmbd_pkg;

    // Number of switchable WRAM banks (2 to 8).
    localparam logic [3:0] SVBK_BANK_COUNT = 4'd8;

    // Target region codes.
    localparam logic [3:0] TGT_CART    = 4'd0;
    localparam logic [3:0] TGT_MAPPER  = 4'd1;
    localparam logic [3:0] TGT_VRAM    = 4'd2;
    localparam logic [3:0] TGT_WFIX    = 4'd3;
    localparam logic [3:0] TGT_WBANK   = 4'd4;
    localparam logic [3:0] TGT_OAM     = 4'd5;
    localparam logic [3:0] TGT_UNUSED  = 4'd6;
    localparam logic [3:0] TGT_IO      = 4'd7;
    localparam logic [3:0] TGT_HRAM    = 4'd8;
    localparam logic [3:0] TGT_BANKREG = 4'd9;

    // Access kinds.
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Configuration register indexes.
    localparam logic REG_COLOR_MODE = 1'b0;

    // Address constants.
    localparam logic [15:0] ECHO_MASK    = 16'hDFFF;
    localparam logic [7:0]  IO_VRAM_BANK = 8'h4F;
    localparam logic [7:0]  IO_WRAM_BANK = 8'h70;
    localparam logic [7:0]  VBK_READ_BASE = 8'hFE;
    localparam logic [7:0]  SVBK_READ_BASE = 8'hF8;
    localparam logic [2:0]  WRAM_BANK_MASK = 3'h7;

    typedef struct packed {
        logic [3:0]  target;
        logic [15:0] offset;
        logic [2:0]  bank;
        logic [7:0]  read_data;
        logic        data_valid;
        logic        dropped;
    } result_t;

endpackage

// ----- rtl/memory_map_bank_decoder.sv -----
`timescale 1ns / 1ps
// Memory map and bank decoder for a handheld console bus.
// Input channel s_axis: one bus access per beat; tuser carries the access kind
// (0 read, 1 write), tdata carries the address and the write byte.
// Output channel m_axis: one decode result per beat: target region, offset
// within the region, selected bank, and an internal read answer or drop flag.
// An APB port holds the color_mode register at byte address 0.
// An accepted input beat reaches the result beat through one input register,
// the decode logic, and the result register. One beat is accepted every cycle
// while results are taken; the rate is set by the single decode stage.
// Writes to the VRAM and WRAM bank registers update the bank state when the
// beat moves into the result register, so the next access already sees it.
// Reset clears the pipeline, sets color_mode to 0, the VRAM bank to 0 and the
// WRAM bank to 1. When the receiver stalls, the result register holds and the
// input register, if empty, takes one more beat before s_axis_tready drops.
module memory_map_bank_decoder
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] address, [23:16] write_data
    input  logic        s_axis_tuser,   // [0] cmd

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] target, [19:4] offset, [22:20] bank, [30:23] read_data,
    // [31] data_valid, [32] dropped, [39:33] zero
    output logic [39:0] m_axis_tdata,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic        color_mode_reg;
    logic        vram_bank_reg;
    logic        vram_bank_next;
    logic [2:0]  wram_bank_reg;
    logic [2:0]  wram_bank_next;

    logic        in_valid_reg;
    logic        in_cmd_reg;
    logic [15:0] in_addr_reg;
    logic [7:0]  in_wdata_reg;

    logic              out_valid_reg;
    mmbd_pkg::result_t out_reg;
    mmbd_pkg::result_t res_next;

    logic in_move;
    logic out_load;
    logic bank_wr;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == mmbd_pkg::REG_COLOR_MODE) ? {31'd0, color_mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == mmbd_pkg::REG_COLOR_MODE)
        begin
            color_mode_reg <= pwdata[0];
        end
    end

    // Handshake between stages.
    assign out_load      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_move       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_move)
        begin
            in_cmd_reg   <= s_axis_tuser;
            in_addr_reg  <= s_axis_tdata[15:0];
            in_wdata_reg <= s_axis_tdata[23:16];
        end
    end

    // Address decode.
    always_comb
    begin
        logic [15:0] a;
        logic        wr;
        logic [2:0]  wb;

        wr = (in_cmd_reg == mmbd_pkg::CMD_WRITE);
        a  = in_addr_reg;
        // Echo RAM folds onto the WRAM window.
        if (a >= 16'hE000 && a <= 16'hFDFF)
        begin
            a = a & mmbd_pkg::ECHO_MASK;
        end

        res_next       = '0;
        bank_wr        = 1'b0;
        vram_bank_next = vram_bank_reg;
        wram_bank_next = wram_bank_reg;

        wb = in_wdata_reg[2:0] & mmbd_pkg::WRAM_BANK_MASK;
        if (wb == 3'd0)
        begin
            wb = 3'd1;
        end
        if ({1'b0, wb} >= mmbd_pkg::SVBK_BANK_COUNT)
        begin
            wb = 3'(mmbd_pkg::SVBK_BANK_COUNT - 4'd1);
        end

        if (a <= 16'h3FFF)
        begin
            res_next.target = wr ? mmbd_pkg::TGT_MAPPER : mmbd_pkg::TGT_CART;
            res_next.offset = a;
        end
        else if (a <= 16'h7FFF)
        begin
            res_next.target = mmbd_pkg::TGT_MAPPER;
            res_next.offset = a;
        end
        else if (a <= 16'h9FFF)
        begin
            res_next.target = mmbd_pkg::TGT_VRAM;
            res_next.offset = a - 16'h8000;
            res_next.bank   = {2'd0, vram_bank_reg};
        end
        else if (a <= 16'hBFFF)
        begin
            res_next.target = mmbd_pkg::TGT_MAPPER;
            res_next.offset = a;
        end
        else if (a <= 16'hCFFF)
        begin
            res_next.target = mmbd_pkg::TGT_WFIX;
            res_next.offset = a - 16'hC000;
        end
        else if (a <= 16'hDFFF)
        begin
            res_next.target = mmbd_pkg::TGT_WBANK;
            res_next.offset = a - 16'hD000;
            res_next.bank   = wram_bank_reg;
        end
        else if (a >= 16'hFE00 && a <= 16'hFE9F)
        begin
            res_next.target = mmbd_pkg::TGT_OAM;
            res_next.offset = a - 16'hFE00;
        end
        else if (a >= 16'hFEA0 && a <= 16'hFEFF)
        begin
            res_next.target     = mmbd_pkg::TGT_UNUSED;
            res_next.offset     = a - 16'hFEA0;
            res_next.dropped    = wr;
            res_next.data_valid = !wr;
        end
        else if (a >= 16'hFF80 && a <= 16'hFFFE)
        begin
            res_next.target = mmbd_pkg::TGT_HRAM;
            res_next.offset = a - 16'hFF80;
        end
        else
        begin
            // IO page, including the top address.
            res_next.offset = {8'd0, a[7:0]};
            if (a[7:0] == mmbd_pkg::IO_VRAM_BANK || a[7:0] == mmbd_pkg::IO_WRAM_BANK)
            begin
                res_next.target = mmbd_pkg::TGT_BANKREG;
                if (wr)
                begin
                    if (!color_mode_reg)
                    begin
                        res_next.dropped = 1'b1;
                    end
                    else
                    begin
                        bank_wr = 1'b1;
                        if (a[7:0] == mmbd_pkg::IO_VRAM_BANK)
                        begin
                            vram_bank_next = in_wdata_reg[0];
                        end
                        else
                        begin
                            wram_bank_next = wb;
                        end
                    end
                end
                else
                begin
                    res_next.data_valid = 1'b1;
                    res_next.read_data  = (a[7:0] == mmbd_pkg::IO_VRAM_BANK)
                        ? mmbd_pkg::VBK_READ_BASE + {7'd0, vram_bank_reg}
                        : mmbd_pkg::SVBK_READ_BASE + {5'd0, wram_bank_reg};
                end
            end
            else
            begin
                res_next.target = mmbd_pkg::TGT_IO;
            end
        end
    end

    // Bank state changes when the writing beat leaves the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vram_bank_reg <= 1'b0;
            wram_bank_reg <= 3'd1;
        end
        else if (in_valid_reg && out_load && bank_wr)
        begin
            vram_bank_reg <= vram_bank_next;
            wram_bank_reg <= wram_bank_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && in_valid_reg)
        begin
            out_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_reg.dropped, out_reg.data_valid, out_reg.read_data,
                            out_reg.bank, out_reg.offset, out_reg.target};

    `include "memory_map_bank_decoder_assert.svh"

    `MMBD_ASSERT_ALWAYS(a_wram_bank_nonzero, wram_bank_reg != 3'd0)
    `MMBD_ASSERT_IMP(a_stall_means_full, !s_axis_tready, in_valid_reg && out_valid_reg)
    `MMBD_ASSERT_IMP(a_valid_drop_exclusive, m_axis_tvalid, !(out_reg.data_valid && out_reg.dropped))
    `MMBD_ASSERT_NEXT(a_mono_banks_hold, !color_mode_reg && !(psel && penable && pwrite), $stable(vram_bank_reg) && $stable(wram_bank_reg))

endmodule

// ----- tb/memory_map_bank_decoder_checker.sv -----
`timescale 1ns / 1ps

module memory_map_bank_decoder_checker
    import mmbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] address, [23:16] write_data
    input  logic        s_axis_tuser,   // [0] cmd

    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] target, [19:4] offset, [22:20] bank, [30:23] read_data,
    // [31] data_valid, [32] dropped, [39:33] zero
    input  logic [39:0] m_axis_tdata,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,

    output int          errors,
    output int          pending
);

    localparam logic [2:0] COLOR_MODE_ADDR = {REG_COLOR_MODE, 2'b00};

    logic       color_mode_q;
    logic       vram_bank_q;
    logic [2:0] wram_bank_q;

    result_t decoded_results[$];

    // Decodes one bus access and applies any bank register write to the bank copies.
    function automatic result_t decode_access(input logic cmd, input logic [15:0] bus_addr,
                                              input logic [7:0] wdata);
        result_t     r;
        logic [15:0] addr;
        logic [7:0]  io_lo;
        logic [2:0]  new_bank;
        r = '0;
        addr = bus_addr;
        if (addr >= 16'hE000 && addr <= 16'hFDFF)
        begin
            addr = addr & ECHO_MASK;
        end
        io_lo = addr[7:0];
        if (addr <= 16'h3FFF)
        begin
            r.target = (cmd == CMD_WRITE) ? TGT_MAPPER : TGT_CART;
            r.offset = addr;
        end
        else if (addr <= 16'h7FFF || (addr >= 16'hA000 && addr <= 16'hBFFF))
        begin
            r.target = TGT_MAPPER;
            r.offset = addr;
        end
        else if (addr <= 16'h9FFF)
        begin
            r.target = TGT_VRAM;
            r.offset = addr - 16'h8000;
            r.bank = {2'b00, vram_bank_q};
        end
        else if (addr <= 16'hCFFF)
        begin
            r.target = TGT_WFIX;
            r.offset = addr - 16'hC000;
        end
        else if (addr <= 16'hDFFF)
        begin
            r.target = TGT_WBANK;
            r.offset = addr - 16'hD000;
            r.bank = wram_bank_q;
        end
        else if (addr >= 16'hFE00 && addr <= 16'hFE9F)
        begin
            r.target = TGT_OAM;
            r.offset = addr - 16'hFE00;
        end
        else if (addr >= 16'hFEA0 && addr <= 16'hFEFF)
        begin
            r.target = TGT_UNUSED;
            r.offset = addr - 16'hFEA0;
            if (cmd == CMD_WRITE)
                r.dropped = 1'b1;
            else
                r.data_valid = 1'b1;
        end
        else if (addr >= 16'hFF80 && addr <= 16'hFFFE)
        begin
            r.target = TGT_HRAM;
            r.offset = addr - 16'hFF80;
        end
        else
        begin
            r.offset = {8'h00, io_lo};
            r.target = TGT_IO;
            if (io_lo == IO_VRAM_BANK || io_lo == IO_WRAM_BANK)
            begin
                r.target = TGT_BANKREG;
                if (cmd == CMD_READ)
                begin
                    r.data_valid = 1'b1;
                    r.read_data = (io_lo == IO_VRAM_BANK) ? VBK_READ_BASE + {7'd0, vram_bank_q}
                                                          : SVBK_READ_BASE + {5'd0, wram_bank_q};
                end
                else if (!color_mode_q)
                begin
                    r.dropped = 1'b1;
                end
                else if (io_lo == IO_VRAM_BANK)
                begin
                    vram_bank_q = wdata[0];
                end
                else
                begin
                    // Bank zero selects bank one; banks past the last one saturate.
                    new_bank = wdata[2:0] & WRAM_BANK_MASK;
                    if (new_bank == 3'd0)
                        new_bank = 3'd1;
                    if ({1'b0, new_bank} >= SVBK_BANK_COUNT)
                        new_bank = 3'(SVBK_BANK_COUNT - 4'd1);
                    wram_bank_q = new_bank;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        errors++;
        $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            color_mode_q = 1'b0;
            vram_bank_q = 1'b0;
            wram_bank_q = 3'd1;
            decoded_results.delete();
            pending = 0;
            errors = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == COLOR_MODE_ADDR)
                color_mode_q = pwdata[0];
            if (s_axis_tvalid && s_axis_tready)
                decoded_results.push_back(decode_access(s_axis_tuser, s_axis_tdata[15:0],
                                                        s_axis_tdata[23:16]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (decoded_results.size() == 0)
                begin
                    report_mismatch("result beat with nothing outstanding, target",
                                    {12'd0, m_axis_tdata[3:0]}, 16'd0);
                end
                else
                begin
                    want = decoded_results.pop_front();
                    if (m_axis_tdata[3:0] != want.target)
                        report_mismatch("target", {12'd0, m_axis_tdata[3:0]},
                                        {12'd0, want.target});
                    if (m_axis_tdata[19:4] != want.offset)
                        report_mismatch("offset", m_axis_tdata[19:4], want.offset);
                    if (m_axis_tdata[22:20] != want.bank)
                        report_mismatch("bank", {13'd0, m_axis_tdata[22:20]},
                                        {13'd0, want.bank});
                    if (m_axis_tdata[30:23] != want.read_data)
                        report_mismatch("read_data", {8'd0, m_axis_tdata[30:23]},
                                        {8'd0, want.read_data});
                    if (m_axis_tdata[31] != want.data_valid)
                        report_mismatch("data_valid", {15'd0, m_axis_tdata[31]},
                                        {15'd0, want.data_valid});
                    if (m_axis_tdata[32] != want.dropped)
                        report_mismatch("dropped", {15'd0, m_axis_tdata[32]},
                                        {15'd0, want.dropped});
                end
            end
            pending = decoded_results.size();
        end
    end

endmodule

// ----- tb/memory_map_bank_decoder_test.sv -----
`timescale 1ns / 1ps

module memory_map_bank_decoder_test;
    import mmbd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_BEATS = 340;
    localparam int IDLE_PERCENT = 11;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // [15:0] address, [23:16] write_data
    logic        s_axis_tuser;   // [0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [3:0] target, [19:4] offset, [22:20] bank, [30:23] read_data,
    // [31] data_valid, [32] dropped, [39:33] zero
    logic [39:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int pending;
    int cycles = 0;
    bit idle_on = 1'b1;

    memory_map_bank_decoder u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    memory_map_bank_decoder_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .errors        (errors),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= !(idle_on && $urandom_range(99) < IDLE_PERCENT);
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("memory_map_bank_decoder: mismatch");
            $finish;
        end
    end

    task automatic send_access(input logic cmd, input logic [15:0] addr,
                               input logic [7:0] wdata);
        while (idle_on && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {wdata, addr};
        s_axis_tuser <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Bias toward the bank registers and the top page so the bank state keeps moving.
    task automatic send_random_access();
        logic [15:0] addr;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 25)
            addr = $urandom_range(1) ? {8'hFF, IO_VRAM_BANK} : {8'hFF, IO_WRAM_BANK};
        else if (pick < 40)
            addr = 16'hFE00 | 16'($urandom_range(511));
        else
            addr = 16'($urandom);
        send_access(1'($urandom_range(1)), addr, 8'($urandom));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_color_mode(input logic [31:0] value);
        wait_drained();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_COLOR_MODE, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= CMD_READ;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Region edges in monochrome mode, where bank register writes are dropped.
        send_access(CMD_READ,  16'h0000, 8'hFF);
        send_access(CMD_WRITE, 16'h3FFF, 8'h00);
        send_access(CMD_READ,  16'h7FFF, 8'hA5);
        send_access(CMD_READ,  16'h8000, 8'h00);
        send_access(CMD_WRITE, 16'hBFFF, 8'h5A);
        send_access(CMD_READ,  16'hC000, 8'h00);
        send_access(CMD_READ,  16'hDFFF, 8'h00);
        send_access(CMD_READ,  16'hE000, 8'h00);
        send_access(CMD_WRITE, 16'hFDFF, 8'h3C);
        send_access(CMD_READ,  16'hFE9F, 8'h00);
        send_access(CMD_READ,  16'hFEA0, 8'h00);
        send_access(CMD_WRITE, 16'hFEFF, 8'hFF);
        send_access(CMD_READ,  16'hFF00, 8'h00);
        send_access(CMD_READ,  {8'hFF, IO_VRAM_BANK}, 8'h00);
        send_access(CMD_WRITE, {8'hFF, IO_WRAM_BANK}, 8'h05);
        send_access(CMD_READ,  16'hFFFE, 8'h00);
        send_access(CMD_READ,  16'hFFFF, 8'h00);

        // Color mode, written with every upper bit set as well.
        write_color_mode(32'hFFFF_FFFF);
        send_access(CMD_WRITE, {8'hFF, IO_WRAM_BANK}, 8'h00);
        send_access(CMD_READ,  {8'hFF, IO_WRAM_BANK}, 8'h00);
        send_access(CMD_WRITE, {8'hFF, IO_VRAM_BANK}, 8'hFF);
        send_access(CMD_READ,  16'h9FFF, 8'h00);
        send_access(CMD_WRITE, {8'hFF, IO_WRAM_BANK}, 8'hFF);
        send_access(CMD_READ,  16'hD000, 8'h00);
        send_access(CMD_READ,  {8'hFF, IO_VRAM_BANK}, 8'h00);

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: write_color_mode(32'h0000_0000);
                1: write_color_mode(32'h0000_0001);
                2: write_color_mode($urandom);
                3: write_color_mode(32'hFFFF_FFFE);
                default: write_color_mode(32'h0000_0001);
            endcase
            // One phase runs with both sides streaming back to back.
            idle_on = (phase != 2);
            for (int n = 0; n < PHASE_BEATS; n++)
                send_random_access();
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("memory_map_bank_decoder: match");
        else
            $display("memory_map_bank_decoder: mismatch");
        $finish;
    end

endmodule
